[rtl/flpd_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-length packet deframer package
// Shared widths, register indexes, status codes and the result record.
// ----------------------------------------------------------------------------
package flpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int WORD_W    = 32;
    localparam int PAYLOAD_W = 40;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_DATA_W = 48;
    localparam int RESULT_W  = STATUS_W + BYTE_W + WORD_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h5A;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd2;

    // Packed so that the status sits in the lowest bits.
    typedef struct packed {
        logic [WORD_W-1:0]   command_word;
        logic [BYTE_W-1:0]   flag_byte;
        logic [STATUS_W-1:0] frame_status;
    } t_result;

endpackage

[rtl/flpd_frame_fsm.sv]
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the frame byte by byte, collects the payload, keeps the running
// sum and forms the result when the tail byte arrives.
// ----------------------------------------------------------------------------
module flpd_frame_fsm
    import flpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_header_value,
    input  logic [BYTE_W-1:0] i_tail_value,
    output logic              o_in_tail,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_P1    = 3'd1,
        PH_P2    = 3'd2,
        PH_P3    = 3'd3,
        PH_P4    = 3'd4,
        PH_P5    = 3'd5,
        PH_CHECK = 3'd6,
        PH_TAIL  = 3'd7
    } t_phase;

    t_phase                 r_phase;
    logic [BYTE_W-1:0]      r_sum;
    logic [PAYLOAD_W-1:0]   r_payload;
    logic [BYTE_W-1:0]      r_checksum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_sum   <= '0;
        end else if (i_accept) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_byte == i_header_value) begin
                        r_sum   <= '0;
                        r_phase <= PH_P1;
                    end
                end
                PH_P1, PH_P2, PH_P3, PH_P4, PH_P5: begin
                    r_sum   <= r_sum + i_byte;
                    r_phase <= t_phase'(r_phase + 3'd1);
                end
                PH_CHECK: r_phase <= PH_TAIL;
                PH_TAIL:  r_phase <= PH_WAIT;
                default:  r_phase <= PH_WAIT;
            endcase
        end
    end

    // Payload and checksum bytes need no reset: a frame writes them all
    // before its tail byte can be seen.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            unique case (r_phase)
                PH_P1:    r_payload[7:0]   <= i_byte;
                PH_P2:    r_payload[15:8]  <= i_byte;
                PH_P3:    r_payload[23:16] <= i_byte;
                PH_P4:    r_payload[31:24] <= i_byte;
                PH_P5:    r_payload[39:32] <= i_byte;
                PH_CHECK: r_checksum       <= i_byte;
                default: ;
            endcase
        end
    end

    assign o_in_tail   = (r_phase == PH_TAIL);
    assign o_res_valid = i_accept && (r_phase == PH_TAIL);

    always_comb begin
        o_res.flag_byte    = r_payload[7:0];
        o_res.command_word = r_payload[39:8];
        priority if (i_byte != i_tail_value) begin
            o_res.frame_status = ST_BAD_TAIL;
        end else if (r_sum != r_checksum) begin
            o_res.frame_status = ST_BAD_SUM;
        end else begin
            o_res.frame_status = ST_OK;
        end
    end

    // A result always closes the frame.
    a_res_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_WAIT))
        else $error("frame not closed after result");

    // A header byte seen while waiting starts a fresh sum.
    a_header_clears_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_WAIT && i_byte == i_header_value)
            |=> (r_sum == '0) && (r_phase == PH_P1))
        else $error("sum not cleared at frame start");

    // The sum in the checksum phase covers exactly five payload bytes.
    a_check_follows_p5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_P5)
            |=> (r_phase == PH_CHECK) && (r_sum == $past(r_sum + i_byte)))
        else $error("payload sum slipped");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.frame_status != 2'd3))
        else $error("unused status code produced");

endmodule

[rtl/flpd_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module flpd_out_reg
    import flpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A new result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_load)
        else $error("result overwritten before taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_res == $past(i_res)))
        else $error("loaded result not presented");

    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !i_load) |=> !r_valid)
        else $error("taken result still shown");

endmodule

[rtl/fixed_length_packet_deframer.sv]
// ----------------------------------------------------------------------------
// Fixed-length packet deframer
// Receives header, five payload bytes, checksum and tail; reports status
// and the assembled flag byte and command word once per frame.
//
//   Channel   Dir  Handshake               Payload
//   s         in   i_s_tvalid/o_s_tready   i_s_tdata: rx_byte
//   m         out  o_m_tvalid/i_m_tready   o_m_tdata: status, flag, command
//   cfg       in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// One byte is accepted per cycle while o_s_tready is high; a frame takes seven bytes after its header.
// The result is registered and appears on the master side in the cycle after the tail byte.
// o_s_tready drops only while the tracker expects a tail byte and the previous
// result is still held in the result register and not being taken.
// Reset is synchronous: the tracker waits for a header, the registers
// return to header 0xA5 and tail 0x5A, and the result register is empty.
// ----------------------------------------------------------------------------
module fixed_length_packet_deframer
    import flpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] rx_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [1:0] frame_status,
                                               // [9:2] flag_byte,
                                               // [41:10] command_word, zero above
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    logic [BYTE_W-1:0] r_header_value;
    logic [BYTE_W-1:0] r_tail_value;

    logic    in_tail;
    logic    can_load;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value <= HEADER_RESET;
            r_tail_value   <= TAIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER: r_header_value <= i_cfg_data;
                CFG_TAIL:   r_tail_value   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Only a tail byte produces a word, so only it waits for room.
    assign o_s_tready = !in_tail || can_load;
    assign accept     = i_s_tvalid && o_s_tready;

    flpd_frame_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_s_tdata),
        .i_header_value (r_header_value),
        .i_tail_value   (r_tail_value),
        .o_in_tail      (in_tail),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    flpd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_ready    (i_m_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .o_res      (out_res)
    );

    assign o_m_tdata = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

endmodule

[sim/tb_fixed_length_packet_deframer.sv]
// ----------------------------------------------------------------------------
// Fixed-length packet deframer testbench
// Drives bytes on the input stream and keeps its own frame tracker that works
// out the status, flag byte and command word of every frame. Results on the
// output stream are checked against the oldest pending prediction. Covers
// directed corner frames, header and tail register changes, a long random
// run with random idling on both sides, and a long output stall.
// ----------------------------------------------------------------------------
module tb_fixed_length_packet_deframer;
    import flpd_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int STALL_CYCLES    = 400;
    localparam int RANDOM_BYTES    = 840;

    // Tracker phases: wait for header, payload bytes 1..5, checksum, tail.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LAST_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_SUM  = 3'd6;
    localparam logic [2:0] PH_TAIL = 3'd7;

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL} t_frame_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [BYTE_W-1:0]     i_s_tdata = '0;     // [7:0] rx_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;          // [1:0] frame_status, [9:2] flag_byte,
                                               // [41:10] command_word, zero above
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [BYTE_W-1:0]     i_cfg_data = '0;

    // Frame tracker state and its copy of the registers.
    logic [BYTE_W-1:0]    hdr_val = HEADER_RESET;
    logic [BYTE_W-1:0]    tail_val = TAIL_RESET;
    logic [2:0]           rx_phase = PH_IDLE;
    logic [PAYLOAD_W-1:0] payload_acc = '0;
    logic [BYTE_W-1:0]    sum_acc = '0;
    logic [BYTE_W-1:0]    csum_rx = '0;

    t_result pending_results[$];
    int      err_cnt = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;
    bit      stall_req = 1'b0;
    int      stall_left = 0;

    fixed_length_packet_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advances the frame tracker by one accepted word.
    task automatic track_byte(input logic [BYTE_W-1:0] b);
        t_result res;
        if (rx_phase == PH_IDLE) begin
            if (b == hdr_val) begin
                sum_acc  = '0;
                rx_phase = 3'd1;
            end
        end else if (rx_phase <= PH_LAST_PAYLOAD) begin
            payload_acc[(int'(rx_phase) - 1) * BYTE_W +: BYTE_W] = b;
            sum_acc  = sum_acc + b;
            rx_phase = rx_phase + 3'd1;
        end else if (rx_phase == PH_SUM) begin
            csum_rx  = b;
            rx_phase = PH_TAIL;
        end else begin
            if (b != tail_val)
                res.frame_status = ST_BAD_TAIL;
            else if (sum_acc != csum_rx)
                res.frame_status = ST_BAD_SUM;
            else
                res.frame_status = ST_OK;
            res.flag_byte    = payload_acc[BYTE_W-1:0];
            res.command_word = payload_acc[PAYLOAD_W-1:BYTE_W];
            pending_results.push_back(res);
            rx_phase = PH_IDLE;
        end
    endtask

    // Starts and ends at a falling edge; valid stays high between words
    // unless an idle cycle is drawn.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        track_byte(b);
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] payload_sum(input logic [BYTE_W-1:0] flag,
                                                      input logic [WORD_W-1:0] word);
        return flag + word[7:0] + word[15:8] + word[23:16] + word[31:24];
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] flag, input logic [WORD_W-1:0] word,
                              input logic [BYTE_W-1:0] csum, input logic [BYTE_W-1:0] tail_b);
        send_byte(hdr_val);
        send_byte(flag);
        for (int k = 0; k < 4; k++)
            send_byte(word[k*BYTE_W +: BYTE_W]);
        send_byte(csum);
        send_byte(tail_b);
    endtask

    task automatic send_random_frame(input t_frame_kind kind);
        logic [BYTE_W-1:0] flag;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] csum;
        logic [BYTE_W-1:0] tail_b;
        flag   = BYTE_W'($urandom_range(255));
        word   = $urandom;
        // Now and then push the command word to all-zero or all-one bytes.
        if ($urandom_range(15) == 0)
            word = '0;
        else if ($urandom_range(15) == 0)
            word = '1;
        csum   = payload_sum(flag, word);
        tail_b = tail_val;
        if (kind == FR_BAD_SUM)
            csum = csum + BYTE_W'($urandom_range(1, 255));
        if (kind == FR_BAD_TAIL) begin
            tail_b = tail_val ^ BYTE_W'($urandom_range(1, 255));
            if ($urandom_range(1) == 1)
                csum = BYTE_W'($urandom_range(255));
        end
        send_frame(flag, word, csum, tail_b);
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return FR_GOOD;
        else if (r < 85)
            return FR_BAD_SUM;
        else
            return FR_BAD_TAIL;
    endfunction

    // Brings the tracker back to header wait, then lets every result drain.
    task automatic settle();
        while (rx_phase != PH_IDLE)
            send_byte(BYTE_W'($urandom_range(255)));
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_HEADER)
            hdr_val = value;
        else
            tail_val = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_reset_values();
        // Bytes that are not the header are dropped while waiting.
        send_byte(8'h00);
        send_byte(8'hFF);
        // A header value inside the payload is plain data.
        send_frame(8'hA5, 32'h00FF00FF, payload_sum(8'hA5, 32'h00FF00FF), tail_val);
        // Wrong tail together with a wrong checksum still reports a bad tail.
        send_frame(8'hFF, 32'hFFFFFFFF, 8'h00, 8'h00);
        // Correct tail, checksum off by one.
        send_frame(8'h01, 32'hA55A7F80, payload_sum(8'h01, 32'hA55A7F80) + 8'd1, tail_val);
        settle();
    endtask

    task automatic test_register_settings();
        logic [BYTE_W-1:0] hdr_list[4];
        logic [BYTE_W-1:0] tail_list[4];
        hdr_list  = '{8'h00, 8'hFF, 8'h3C, HEADER_RESET};
        tail_list = '{8'hFF, 8'h00, 8'h3C, TAIL_RESET};
        for (int s = 0; s < 4; s++) begin
            write_reg(CFG_HEADER, hdr_list[s]);
            write_reg(CFG_TAIL, tail_list[s]);
            send_byte(hdr_val ^ 8'h80);
            send_random_frame(FR_GOOD);
            send_random_frame(FR_BAD_SUM);
            send_random_frame(FR_BAD_TAIL);
            send_random_frame(FR_GOOD);
            settle();
        end
    endtask

    task automatic test_random_traffic();
        int frame_bytes;
        int frames;
        int n_noise;
        frame_bytes = 0;
        frames = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if (frames % 40 == 39) begin
                settle();
                if ($urandom_range(3) != 0)
                    write_reg(CFG_HEADER, BYTE_W'($urandom_range(255)));
                if ($urandom_range(3) != 0)
                    write_reg(CFG_TAIL, BYTE_W'($urandom_range(255)));
            end
            // A long stretch with no idling on either side.
            idle_on = !(frames >= 50 && frames < 90);
            if ($urandom_range(99) < 12) begin
                // Raw bytes: may start or break a frame.
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) send_byte(BYTE_W'($urandom_range(255)));
            end else begin
                send_random_frame(pick_kind());
                frame_bytes += 8;
            end
            frames++;
        end
        idle_on = 1'b1;
        settle();
    endtask

    task automatic test_output_stall();
        idle_on   = 1'b0;
        stall_req = 1'b1;
        repeat (20) send_random_frame(pick_kind());
        idle_on = 1'b1;
        settle();
        write_reg(CFG_HEADER, HEADER_RESET);
        write_reg(CFG_TAIL, TAIL_RESET);
    endtask

    // Receiver side: random ready, or a counted hold-off on request.
    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_left = STALL_CYCLES;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(99) < 22) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t ERROR unexpected result, got %h", $time, o_m_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got.frame_status !== want.frame_status) begin
                    $display("%0t ERROR frame_status expected %0d actual %0d",
                             $time, want.frame_status, got.frame_status);
                    err_cnt++;
                end
                if (got.flag_byte !== want.flag_byte) begin
                    $display("%0t ERROR flag_byte expected %h actual %h",
                             $time, want.flag_byte, got.flag_byte);
                    err_cnt++;
                end
                if (got.command_word !== want.command_word) begin
                    $display("%0t ERROR command_word expected %h actual %h",
                             $time, want.command_word, got.command_word);
                    err_cnt++;
                end
            end
            if (o_m_tdata[OUT_DATA_W-1:RESULT_W] !== '0) begin
                $display("%0t ERROR tdata padding expected 0 actual %h",
                         $time, o_m_tdata[OUT_DATA_W-1:RESULT_W]);
                err_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_values();
        test_register_settings();
        test_random_traffic();
        test_output_stall();
        repeat (10) @(negedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
